/* hw/rtl/assert_macros.svh */
// Concurrent check helpers. The caller provides clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication.
`define CHK_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

/* hw/rtl/tpf_pkg.sv */
`timescale 1ns / 1ps
package tpf_pkg;

	localparam int SLOT_W = 6;

	typedef enum logic [1:0] {
		OP_LIMITS = 2'd0,
		OP_ENTRY  = 2'd1,
		OP_EVAL   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		K_NOP,
		K_LOAD,
		K_EVAL,
		K_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [SLOT_W-1:0]  slot;
		logic [13:0]        tix;
		logic signed [31:0] ew;
		logic signed [31:0] sw;
		logic signed [23:0] dx;
		logic signed [23:0] dy;
		logic signed [23:0] dz;
		logic [47:0]        rsq;
		logic [23:0]        start;
	} req_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_LOAD,
		BK_SQRT,
		BK_PREP,
		BK_DIV,
		BK_RD0,
		BK_RD1,
		BK_RD2,
		BK_MULI,
		BK_INTP,
		BK_MULF,
		BK_FIN,
		BK_RES
	} bk_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [55:0] x);
		logic signed [31:0] r;
		if (x > 56'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (x < -56'sd2147483648)
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
		logic signed [47:0] r;
		if (x[48] != x[47])
			r = x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			r = x[47:0];
		return r;
	endfunction

endpackage

/* hw/rtl/tpf_front.sv */
`timescale 1ns / 1ps
module tpf_front import tpf_pkg::*; #(
	parameter int TYPE_COUNT  = 4,
	parameter int TABLE_STEPS = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [1:0]         type_a,
	input  logic [1:0]         type_b,
	input  logic [13:0]        table_index,
	input  logic signed [23:0] delta_x,
	input  logic signed [23:0] delta_y,
	input  logic signed [23:0] delta_z,
	input  logic signed [31:0] energy_word,
	input  logic signed [31:0] slope_word,
	input  logic [47:0]        outer_limit_sq,
	input  logic [47:0]        inner_limit_sq,
	input  logic [23:0]        start_distance,
	output logic               push,
	output req_t               req,
	input  logic               full
);

	localparam int SLOTS = TYPE_COUNT * TYPE_COUNT;
	localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic               v_s1, v_s2;
	logic [1:0]         op_s1, ta_s1, tb_s1;
	logic [1:0]         op_s2, ta_s2, tb_s2;
	logic [13:0]        tix_s1, tix_s2;
	logic signed [23:0] dx_s1, dy_s1, dz_s1, dx_s2, dy_s2, dz_s2;
	logic signed [31:0] ew_s1, sw_s1, ew_s2, sw_s2;
	logic [47:0]        outer_s1, inner_s1, outer_s2, inner_s2;
	logic [23:0]        start_s1, start_s2;
	logic [46:0]        sqx_s2, sqy_s2, sqz_s2;

	logic [47:0] outer_q [0:SLOTS-1];
	logic [47:0] inner_q [0:SLOTS-1];
	logic [23:0] start_q [0:SLOTS-1];

	logic               adv1, adv2, s2_free, accept, types_ok, hit;
	logic signed [47:0] px, py, pz;
	logic [47:0]        rsq;
	logic [SLOT_W-1:0]  slot;
	logic [SIW-1:0]     sidx;
	kind_t              kind;

	assign adv2     = v_s2 && !full;
	assign s2_free  = !v_s2 || adv2;
	assign adv1     = v_s1 && s2_free;
	assign in_stall = v_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !adv1);
			v_s2 <= adv1 || (v_s2 && !adv2);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode;
			ta_s1    <= type_a;
			tb_s1    <= type_b;
			tix_s1   <= table_index;
			dx_s1    <= delta_x;
			dy_s1    <= delta_y;
			dz_s1    <= delta_z;
			ew_s1    <= energy_word;
			sw_s1    <= slope_word;
			outer_s1 <= outer_limit_sq;
			inner_s1 <= inner_limit_sq;
			start_s1 <= start_distance;
		end
		if (adv1) begin
			op_s2    <= op_s1;
			ta_s2    <= ta_s1;
			tb_s2    <= tb_s1;
			tix_s2   <= tix_s1;
			dx_s2    <= dx_s1;
			dy_s2    <= dy_s1;
			dz_s2    <= dz_s1;
			ew_s2    <= ew_s1;
			sw_s2    <= sw_s1;
			outer_s2 <= outer_s1;
			inner_s2 <= inner_s1;
			start_s2 <= start_s1;
			sqx_s2   <= px[46:0];
			sqy_s2   <= py[46:0];
			sqz_s2   <= pz[46:0];
		end
	end

	assign types_ok = (32'(ta_s2) < TYPE_COUNT) && (32'(tb_s2) < TYPE_COUNT);
	assign slot     = types_ok ? SLOT_W'(32'(ta_s2) * TYPE_COUNT + 32'(tb_s2)) : '0;
	assign sidx     = slot[SIW-1:0];
	assign rsq      = {1'b0, sqx_s2} + {1'b0, sqy_s2} + {1'b0, sqz_s2};
	assign hit      = types_ok && (outer_q[sidx] != '0) && (rsq <= outer_q[sidx])
		&& (rsq >= inner_q[sidx]);

	// Limits update in queue order, at the same stage that reads them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				outer_q[i] <= '0;
				inner_q[i] <= '0;
				start_q[i] <= '0;
			end
		end else if (adv2 && op_t'(op_s2) == OP_LIMITS && types_ok) begin
			outer_q[sidx] <= outer_s2;
			inner_q[sidx] <= inner_s2;
			start_q[sidx] <= start_s2;
		end
	end

	always_comb begin
		unique case (op_t'(op_s2))
			OP_LIMITS: kind = K_NOP;
			OP_ENTRY:  kind = (types_ok && 32'(tix_s2) <= TABLE_STEPS) ? K_LOAD : K_NOP;
			OP_EVAL:   kind = hit ? K_EVAL : K_NOP;
			OP_CLEAR:  kind = K_CLEAR;
			default:   kind = K_NOP;
		endcase
	end

	assign push      = adv2;
	assign req.kind  = kind;
	assign req.slot  = slot;
	assign req.tix   = tix_s2;
	assign req.ew    = ew_s2;
	assign req.sw    = sw_s2;
	assign req.dx    = dx_s2;
	assign req.dy    = dy_s2;
	assign req.dz    = dz_s2;
	assign req.rsq   = rsq;
	assign req.start = start_q[sidx];

endmodule

/* hw/rtl/tpf_queue.sv */
`timescale 1ns / 1ps
module tpf_queue import tpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t wdata,
	output logic full,
	input  logic pop,
	output req_t head,
	output logic empty
);

	req_t       mem_q [0:1];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule

/* hw/rtl/tpf_back.sv */
`timescale 1ns / 1ps
module tpf_back import tpf_pkg::*; #(
	parameter int TYPE_COUNT  = 4,
	parameter int TABLE_STEPS = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  req_t               head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               in_range,
	output logic signed [31:0] pair_energy,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic signed [47:0] energy_total
);

	localparam int SLOTS   = TYPE_COUNT * TYPE_COUNT;
	localparam int ROW_LEN = TABLE_STEPS + 1;
	localparam int DEPTH   = SLOTS * ROW_LEN;
	localparam int AW      = $clog2(DEPTH);
	localparam int IW      = $clog2(ROW_LEN);
	localparam int NW      = 24 + IW;
	localparam int RTW     = $clog2(TABLE_STEPS) + 16;
	localparam int CW      = $clog2(NW);
	localparam logic [NW-1:0] LIM = NW'(TABLE_STEPS - 1) << 16;

	bk_state_t state_q, state_d;

	req_t               cur_q;
	logic [AW-1:0]      row_q;
	logic [CW-1:0]      cnt_q;
	logic [47:0]        sv_q;
	logic [24:0]        srem_q;
	logic [23:0]        root_q;
	logic [NW-1:0]      num_q;
	logic [NW-1:0]      dq_q;
	logic [IW-1:0]      base_q;
	logic [16:0]        w_q;
	logic signed [31:0] e0_q, e1_q, s0_q, s1_q, energy_q, slope_q;
	logic signed [50:0] pe_q, ps_q;
	logic signed [55:0] fx_q, fy_q, fz_q;
	logic signed [47:0] sum_q;
	logic               res_hit_q;
	logic signed [31:0] res_e_q, res_fx_q, res_fy_q, res_fz_q;
	logic               out_valid_q;

	logic signed [31:0] emem [0:DEPTH-1];
	logic signed [31:0] smem [0:DEPTH-1];
	logic signed [31:0] erd, srd;
	logic [AW-1:0]      rd_addr, wr_addr;

	logic               out_load;
	logic [26:0]        rem_n, trial;
	logic [24:0]        rdiff;
	logic [23:0]        r_c;
	logic [NW-1:0]      dsum0, dsum1, dsum2, dten, drem;
	logic [NW-1:0]      rt_w;
	logic [RTW-1:0]     rt_c;
	logic [IW-1:0]      base_c;
	logic signed [35:0] ve, vs;

	assign pop      = (state_q == BK_IDLE) && !empty;
	assign out_load = (state_q == BK_RES) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					unique case (head.kind)
						K_LOAD:  state_d = BK_LOAD;
						K_EVAL:  state_d = BK_SQRT;
						default: state_d = BK_RES;
					endcase
				end
			end
			BK_LOAD: state_d = BK_RES;
			BK_SQRT: if (cnt_q == '0) state_d = BK_PREP;
			BK_PREP: state_d = BK_DIV;
			BK_DIV:  if (cnt_q == '0) state_d = BK_RD0;
			BK_RD0:  state_d = BK_RD1;
			BK_RD1:  state_d = BK_RD2;
			BK_RD2:  state_d = BK_MULI;
			BK_MULI: state_d = BK_INTP;
			BK_INTP: state_d = BK_MULF;
			BK_MULF: state_d = BK_FIN;
			BK_FIN:  state_d = BK_RES;
			BK_RES:  if (out_load) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// One root bit per step.
	assign rem_n = {srem_q, sv_q[47:46]};
	assign trial = {1'b0, root_q, 2'b01};

	assign rdiff = {1'b0, root_q} - {1'b0, cur_q.start};
	assign r_c   = rdiff[24] ? '0 : rdiff[23:0];

	// Divide by ten: scale by 0.8 with shift-adds, drop three bits, then fix the
	// estimate, which is at most one low, from the remainder.
	assign dsum0 = (num_q >> 1) + (num_q >> 2);
	assign dsum1 = dq_q + (dq_q >> 8);
	assign dsum2 = dq_q + (dq_q >> 32);
	assign dten  = (dq_q << 3) + (dq_q << 1);
	assign drem  = num_q - dten;

	assign rt_w   = (num_q > LIM) ? LIM : num_q;
	assign rt_c   = rt_w[RTW-1:0];
	assign base_c = IW'(rt_c[RTW-1:16]) + IW'(rt_c[15:0] != 16'd0);

	always_comb begin
		priority if (state_q == BK_RD0)
			rd_addr = row_q + AW'(base_c);
		else if (state_q == BK_RD1)
			rd_addr = row_q + AW'(base_q) + AW'(1);
		else
			rd_addr = row_q + AW'(base_q);
	end
	assign wr_addr = row_q + AW'(cur_q.tix);

	always_ff @(posedge clk) begin
		if (state_q == BK_LOAD) begin
			emem[wr_addr] <= cur_q.ew;
			smem[wr_addr] <= cur_q.sw;
		end
		erd <= emem[rd_addr];
		srd <= smem[rd_addr];
	end

	assign ve = 36'(e0_q) + 36'(pe_q >>> 16);
	assign vs = 36'(s0_q) + 36'(ps_q >>> 16);

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					cur_q     <= head;
					row_q     <= AW'(head.slot) * AW'(ROW_LEN);
					sv_q      <= head.rsq;
					srem_q    <= '0;
					root_q    <= '0;
					cnt_q     <= CW'(23);
					res_hit_q <= 1'b0;
					res_e_q   <= '0;
					res_fx_q  <= '0;
					res_fy_q  <= '0;
					res_fz_q  <= '0;
				end
			end
			BK_SQRT: begin
				sv_q  <= sv_q << 2;
				cnt_q <= cnt_q - CW'(1);
				if (rem_n >= trial) begin
					srem_q <= 25'(rem_n - trial);
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					srem_q <= rem_n[24:0];
					root_q <= {root_q[22:0], 1'b0};
				end
			end
			BK_PREP: begin
				num_q <= NW'(r_c) * NW'(TABLE_STEPS);
				cnt_q <= CW'(3);
			end
			BK_DIV: begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(3))
					dq_q <= dsum0 + (dsum0 >> 4);
				else if (cnt_q == CW'(2))
					dq_q <= dsum1 + (dsum1 >> 16);
				else if (cnt_q == CW'(1))
					dq_q <= dsum2 >> 3;
				else
					num_q <= dq_q + NW'(drem > NW'(9));
			end
			BK_RD0: begin
				base_q <= base_c;
				w_q    <= (rt_c[15:0] == 16'd0) ? 17'h10000 : {1'b0, rt_c[15:0]};
			end
			BK_RD1: begin
				e0_q <= erd;
				s0_q <= srd;
			end
			BK_RD2: begin
				e1_q <= erd;
				s1_q <= srd;
			end
			BK_MULI: begin
				pe_q <= (33'(e1_q) - 33'(e0_q)) * $signed({1'b0, w_q});
				ps_q <= (33'(s1_q) - 33'(s0_q)) * $signed({1'b0, w_q});
			end
			BK_INTP: begin
				energy_q <= sat32(56'(ve));
				slope_q  <= sat32(56'(vs));
			end
			BK_MULF: begin
				fx_q <= slope_q * cur_q.dx;
				fy_q <= slope_q * cur_q.dy;
				fz_q <= slope_q * cur_q.dz;
			end
			BK_FIN: begin
				res_hit_q <= 1'b1;
				res_e_q   <= energy_q;
				res_fx_q  <= sat32(fx_q >>> 16);
				res_fy_q  <= sat32(fy_q >>> 16);
				res_fz_q  <= sat32(fz_q >>> 16);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (pop && head.kind == K_CLEAR) begin
			sum_q <= '0;
		end else if (state_q == BK_FIN) begin
			sum_q <= sat48(49'(sum_q) + 49'(energy_q));
		end
	end

	// Hold the result until taken; the queue keeps filling meanwhile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			in_range     <= res_hit_q;
			pair_energy  <= res_e_q;
			force_x      <= res_fx_q;
			force_y      <= res_fy_q;
			force_z      <= res_fz_q;
			energy_total <= sum_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/tabulated_pair_force_kernel.sv */
`timescale 1ns / 1ps
// Evaluates one atom pair per evaluate request against a loaded energy/slope table and
// returns one result per request of any opcode, in order. A two-stage front squares the
// separation, checks the per-type-pair cutoffs and updates the limit registers; a
// two-entry queue feeds a back end that works one request at a time. An evaluated pair
// in range holds the back end from its pop to its result for the bit-serial square root,
// the shift-and-add divide by ten and the setup, the two reads of the table memory,
// interpolation, force products and the result load. A table load in range writes its
// entry before its result; other requests go straight to their result. A stalled result
// holds the back end for as long as the stall lasts. The table memory has no reset; an
// entry must be loaded before an evaluation reads it.
module tabulated_pair_force_kernel import tpf_pkg::*; #(
	parameter int TYPE_COUNT  = 4,
	parameter int TABLE_STEPS = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [1:0]         type_a,
	input  logic [1:0]         type_b,
	input  logic [13:0]        table_index,
	input  logic signed [23:0] delta_x,
	input  logic signed [23:0] delta_y,
	input  logic signed [23:0] delta_z,
	input  logic signed [31:0] energy_word,
	input  logic signed [31:0] slope_word,
	input  logic [47:0]        outer_limit_sq,
	input  logic [47:0]        inner_limit_sq,
	input  logic [23:0]        start_distance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               in_range,
	output logic signed [31:0] pair_energy,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic signed [47:0] energy_total
);

`include "assert_macros.svh"

	logic q_push, q_full, q_pop, q_empty;
	req_t q_wdata, q_head;

	tpf_front #(
		.TYPE_COUNT  (TYPE_COUNT),
		.TABLE_STEPS (TABLE_STEPS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.type_a         (type_a),
		.type_b         (type_b),
		.table_index    (table_index),
		.delta_x        (delta_x),
		.delta_y        (delta_y),
		.delta_z        (delta_z),
		.energy_word    (energy_word),
		.slope_word     (slope_word),
		.outer_limit_sq (outer_limit_sq),
		.inner_limit_sq (inner_limit_sq),
		.start_distance (start_distance),
		.push           (q_push),
		.req            (q_wdata),
		.full           (q_full)
	);

	tpf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty)
	);

	tpf_back #(
		.TYPE_COUNT  (TYPE_COUNT),
		.TABLE_STEPS (TABLE_STEPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (q_empty),
		.head         (q_head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.in_range     (in_range),
		.pair_energy  (pair_energy),
		.force_x      (force_x),
		.force_y      (force_y),
		.force_z      (force_z),
		.energy_total (energy_total)
	);

	`CHK_IMP(a_no_push_full, q_push, !q_full)
	`CHK_IMP(a_no_pop_empty, q_pop, !q_empty)
	`CHK_NXT(a_one_at_a_time, q_pop, !q_pop)
	`CHK_IMP(a_skip_zero, out_valid && !in_range,
		pair_energy == 32'sd0 && force_x == 32'sd0 && force_y == 32'sd0 && force_z == 32'sd0)

endmodule

/* dv/tb_tabulated_pair_force_kernel.sv */
`timescale 1ns / 1ps
module tb_tabulated_pair_force_kernel;
	import tpf_pkg::*;

	localparam int TYPES = 4;
	localparam int STEPS = 8192;
	localparam int ROW = STEPS + 1;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int TARGET_REQUESTS = 650;
	localparam longint ONE_A = 65536;

	typedef struct {
		op_t                opc;
		logic [1:0]         ta;
		logic [1:0]         tb;
		logic [13:0]        tix;
		logic signed [23:0] dx;
		logic signed [23:0] dy;
		logic signed [23:0] dz;
		logic signed [31:0] ew;
		logic signed [31:0] sw;
		logic [47:0]        outer;
		logic [47:0]        inner;
		logic [23:0]        start;
	} pair_req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] energy;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic signed [47:0] total;
	} pair_res_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic [1:0]         type_a;
	logic [1:0]         type_b;
	logic [13:0]        table_index;
	logic signed [23:0] delta_x;
	logic signed [23:0] delta_y;
	logic signed [23:0] delta_z;
	logic signed [31:0] energy_word;
	logic signed [31:0] slope_word;
	logic [47:0]        outer_limit_sq;
	logic [47:0]        inner_limit_sq;
	logic [23:0]        start_distance;
	logic               out_valid;
	logic               out_stall;
	logic               in_range;
	logic signed [31:0] pair_energy;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;
	logic signed [47:0] energy_total;

	tabulated_pair_force_kernel u_top (.*);

	// predictor state
	longint unsigned outer_sq[TYPES*TYPES];
	longint unsigned inner_sq[TYPES*TYPES];
	longint          start_dist[TYPES*TYPES];
	longint          energy_rows[int];
	longint          slope_rows[int];
	longint          energy_acc;

	pair_res_t expected_q[$];
	int        mismatches;
	int        requests_sent;
	int        pairs_hit;
	int        pairs_skipped;
	int        clears_seen;
	int        burst_left;
	longint    cycles = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint clamp(input longint x, input longint lo, input longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	// cutoff test and table position of an evaluation under the current limits
	function automatic void locate_pair(input pair_req_t r, output bit hit, output int base,
			output longint rt);
		int slot;
		longint d[3];
		longint unsigned rsq;
		longint sep;
		slot = r.ta * TYPES + r.tb;
		d[0] = longint'(r.dx);
		d[1] = longint'(r.dy);
		d[2] = longint'(r.dz);
		rsq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
		hit = outer_sq[slot] != 0 && rsq <= outer_sq[slot] && rsq >= inner_sq[slot];
		base = 0;
		rt = 0;
		if (hit) begin
			sep = longint'(int_sqrt(rsq)) - start_dist[slot];
			if (sep < 0)
				sep = 0;
			rt = (sep * STEPS) / 10;
			if (rt > longint'(STEPS - 1) * ONE_A)
				rt = longint'(STEPS - 1) * ONE_A;
			base = int'((rt + 65535) >>> 16);
		end
	endfunction

	function automatic longint lerp(input longint e0, input longint e1, input longint w);
		return clamp(e0 + (((e1 - e0) * w) >>> 16), -64'sd2147483648, 64'sd2147483647);
	endfunction

	function automatic pair_res_t predict_pair(input pair_req_t r);
		pair_res_t res;
		int slot, key, base;
		bit hit;
		longint rt, w, slope;
		res = '0;
		slot = r.ta * TYPES + r.tb;
		case (r.opc)
			OP_LIMITS: begin
				outer_sq[slot] = 64'(r.outer);
				inner_sq[slot] = 64'(r.inner);
				start_dist[slot] = longint'(r.start);
			end
			OP_ENTRY: begin
				if (r.tix <= STEPS) begin
					energy_rows[slot * ROW + r.tix] = longint'(r.ew);
					slope_rows[slot * ROW + r.tix] = longint'(r.sw);
				end
			end
			OP_CLEAR: begin
				energy_acc = 0;
				clears_seen++;
			end
			default: begin
				locate_pair(r, hit, base, rt);
				if (hit) begin
					key = slot * ROW + base;
					w = rt - (longint'(base) <<< 16) + 65536;
					res.hit = 1'b1;
					res.energy = 32'(lerp(energy_rows[key], energy_rows[key+1], w));
					slope = lerp(slope_rows[key], slope_rows[key+1], w);
					res.fx = 32'(clamp((slope * longint'(r.dx)) >>> 16, -64'sd2147483648,
						64'sd2147483647));
					res.fy = 32'(clamp((slope * longint'(r.dy)) >>> 16, -64'sd2147483648,
						64'sd2147483647));
					res.fz = 32'(clamp((slope * longint'(r.dz)) >>> 16, -64'sd2147483648,
						64'sd2147483647));
					energy_acc = clamp(energy_acc + longint'(res.energy), -(64'sd1 <<< 47),
						(64'sd1 <<< 47) - 1);
					pairs_hit++;
				end else begin
					pairs_skipped++;
				end
			end
		endcase
		res.total = energy_acc[47:0];
		return res;
	endfunction

	function automatic pair_req_t random_req();
		pair_req_t r;
		r.opc = op_t'($urandom_range(0, 3));
		r.ta = 2'($urandom);
		r.tb = 2'($urandom);
		r.tix = 14'($urandom);
		r.dx = 24'($urandom);
		r.dy = 24'($urandom);
		r.dz = 24'($urandom);
		r.ew = $urandom;
		r.sw = $urandom;
		r.outer = 48'({$urandom, $urandom});
		r.inner = 48'({$urandom, $urandom});
		r.start = 24'($urandom);
		return r;
	endfunction

	function automatic logic signed [23:0] near_delta(input int span);
		return 24'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic send_request(input pair_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		opcode = r.opc;
		type_a = r.ta;
		type_b = r.tb;
		table_index = r.tix;
		delta_x = r.dx;
		delta_y = r.dy;
		delta_z = r.dz;
		energy_word = r.ew;
		slope_word = r.sw;
		outer_limit_sq = r.outer;
		inner_limit_sq = r.inner;
		start_distance = r.start;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(predict_pair(r));
		burst_left--;
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic load_limits(input logic [1:0] ta, input logic [1:0] tb,
			input logic [47:0] outer, input logic [47:0] inner, input logic [23:0] start);
		pair_req_t r;
		r = random_req();
		r.opc = OP_LIMITS;
		r.ta = ta;
		r.tb = tb;
		r.outer = outer;
		r.inner = inner;
		r.start = start;
		send_request(r);
	endtask

	task automatic load_entry(input logic [1:0] ta, input logic [1:0] tb,
			input logic [13:0] tix, input logic [31:0] ew, input logic [31:0] sw);
		pair_req_t r;
		r = random_req();
		r.opc = OP_ENTRY;
		r.ta = ta;
		r.tb = tb;
		r.tix = tix;
		r.ew = ew;
		r.sw = sw;
		send_request(r);
	endtask

	task automatic clear_sum();
		pair_req_t r;
		r = random_req();
		r.opc = OP_CLEAR;
		send_request(r);
	endtask

	// load whichever of the two table entries an in-range pair will read are not yet loaded, then evaluate it
	task automatic eval_pair(input logic [1:0] ta, input logic [1:0] tb,
			input logic signed [23:0] dx, input logic signed [23:0] dy,
			input logic signed [23:0] dz);
		pair_req_t r;
		bit hit;
		int base, slot;
		longint rt;
		r = random_req();
		r.opc = OP_EVAL;
		r.ta = ta;
		r.tb = tb;
		r.dx = dx;
		r.dy = dy;
		r.dz = dz;
		slot = ta * TYPES + tb;
		locate_pair(r, hit, base, rt);
		if (hit) begin
			for (int i = 0; i < 2; i++)
				if (!energy_rows.exists(slot * ROW + base + i))
					load_entry(ta, tb, 14'(base + i), $urandom, $urandom);
		end
		send_request(r);
	endtask

	task automatic drain_results();
		in_valid = 1'b0;
		burst_left = 0;
		while (expected_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed_cases();
		// slot 0: 8 A outer, 0.5 A inner, start 1 A
		load_limits(2'd0, 2'd0, 48'd64 << 32, 48'd1 << 30, 24'd1 << 16);
		// slot 1: every distance in range, start at zero
		load_limits(2'd0, 2'd1, 48'hFFFF_FFFF_FFFF, 48'd0, 24'd0);
		load_entry(2'd0, 2'd0, 14'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		load_entry(2'd0, 2'd0, 14'd1, 32'h8000_0000, 32'h7FFF_FFFF);
		// ignored loads beyond the table end
		load_entry(2'd0, 2'd0, 14'd8193, $urandom, $urandom);
		load_entry(2'd0, 2'd0, 14'h3FFF, $urandom, $urandom);
		eval_pair(2'd0, 2'd0, 24'sd45875, 24'sd0, 24'sd0);            // below start
		eval_pair(2'd0, 2'd0, -24'sd30000, 24'sd20000, -24'sd10000);  // below start
		eval_pair(2'd0, 2'd0, 24'sd600000, 24'sd0, 24'sd0);           // above outer
		eval_pair(2'd0, 2'd0, 24'sd1000, 24'sd2000, 24'sd3000);       // below inner
		eval_pair(2'd0, 2'd0, 24'sd200000, -24'sd150000, 24'sd90000); // mid table
		eval_pair(2'd1, 2'd0, 24'sd65536, 24'sd0, 24'sd0);            // disabled pair
		eval_pair(2'd0, 2'd1, -24'sd8388608, -24'sd8388608, -24'sd8388608);
		eval_pair(2'd0, 2'd1, 24'sd8388607, 24'sd8388607, 24'sd8388607);
		eval_pair(2'd0, 2'd1, 24'sd1310720, 24'sd0, 24'sd0);          // beyond table
		eval_pair(2'd0, 2'd1, 24'sd0, 24'sd0, 24'sd0);
		clear_sum();
		load_limits(2'd3, 2'd3, 48'hFFFF_FFFF_FFFF, 48'd0, 24'hFF_FFFF);
		eval_pair(2'd3, 2'd3, 24'sd300000, 24'sd0, -24'sd4);
		drain_results();
	endtask

	task automatic test_random_stream();
		int k;
		for (int s = 0; s < TYPES * TYPES; s++)
			load_limits(2'(s / TYPES), 2'(s % TYPES),
				48'({$urandom_range(2, 12) * ONE_A} * {$urandom_range(2, 12) * ONE_A}),
				48'($urandom_range(0, 98304) * 64'($urandom_range(0, 98304))),
				24'($urandom_range(0, 3 << 16)));
		while (requests_sent < TARGET_REQUESTS) begin
			k = $urandom_range(0, 99);
			if (k < 8) begin
				case ($urandom_range(0, 5))
					0: load_limits(2'($urandom), 2'($urandom), 48'd0,
						48'({$urandom, $urandom}), 24'($urandom));
					1: load_limits(2'($urandom), 2'($urandom), 48'hFFFF_FFFF_FFFF,
						48'({$urandom, $urandom}), 24'hFF_FFFF);
					default: load_limits(2'($urandom), 2'($urandom),
						48'($urandom_range(ONE_A, 12 * ONE_A) * 64'($urandom_range(ONE_A,
						12 * ONE_A))), 48'($urandom_range(0, 98304) * 64'($urandom_range(0,
						98304))), 24'($urandom_range(0, 4 << 16)));
				endcase
			end else if (k < 12) begin
				clear_sum();
			end else if (k < 22) begin
				load_entry(2'($urandom), 2'($urandom), ($urandom_range(0, 7) == 0) ?
					14'($urandom) : 14'($urandom_range(0, STEPS)), $urandom, $urandom);
			end else if (k < 30) begin
				eval_pair(2'($urandom), 2'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom));
			end else begin
				eval_pair(2'($urandom), 2'($urandom), near_delta(int'(6 * ONE_A)),
					near_delta(int'(6 * ONE_A)), near_delta(int'(6 * ONE_A)));
			end
			// hold off until the pipeline is empty now and then
			if ($urandom_range(0, 199) == 0)
				drain_results();
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			case ((cycles / 300) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (cycles % 7) < 3;
			endcase
		end
	end

	always @(posedge clk) begin
		pair_res_t got, exp;
		if (arst_n && out_valid && !out_stall) begin
			got = '{in_range, pair_energy, force_x, force_y, force_z, energy_total};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: %p", got);
			end else begin
				exp = expected_q.pop_front();
				if (got !== exp) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Result mismatch: expected hit=%0d e=%0d f=(%0d %0d %0d) sum=%0d",
							exp.hit, exp.energy, exp.fx, exp.fy, exp.fz, exp.total);
						$display("                 got hit=%0d e=%0d f=(%0d %0d %0d) sum=%0d",
							got.hit, got.energy, got.fx, got.fy, got.fz, got.total);
					end
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		requests_sent = 0;
		pairs_hit = 0;
		pairs_skipped = 0;
		clears_seen = 0;
		burst_left = 0;
		energy_acc = 0;
		for (int s = 0; s < TYPES * TYPES; s++) begin
			outer_sq[s] = 0;
			inner_sq[s] = 0;
			start_dist[s] = 0;
		end
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_LIMITS;
		type_a = '0;
		type_b = '0;
		table_index = '0;
		delta_x = '0;
		delta_y = '0;
		delta_z = '0;
		energy_word = '0;
		slope_word = '0;
		outer_limit_sq = '0;
		inner_limit_sq = '0;
		start_distance = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_random_stream();
		drain_results();
		repeat (100) @(posedge clk);
		$display("Sent %0d requests: %0d pairs in range, %0d skipped, %0d sum clears",
			requests_sent, pairs_hit, pairs_skipped, clears_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
